// ----- src/msp3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package msp3_pkg;

    // Point set limits and field widths
    localparam int MaxPoints = 1024;
    localparam int CoordW    = 16;
    localparam int IdxW      = 10;
    localparam int CntW      = $clog2(MaxPoints + 1);

    // Distance arithmetic: |a - b| of two signed coords fits CoordW unsigned bits
    localparam int DiffW = CoordW;
    localparam int SqW   = 2 * DiffW;
    localparam int SumW  = SqW + 2;

    // Extreme slots: min x, max x, min y, max y, min z, max z
    localparam int NumAxes  = 3;
    localparam int NumSlots = 2 * NumAxes;

    // Axis codes for the chosen pair
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic [IdxW-1:0]          t_idx;

    typedef struct packed {
        logic signed [CoordW-1:0] coord_x;
        logic signed [CoordW-1:0] coord_y;
        logic signed [CoordW-1:0] coord_z;
        logic                     last_point;
    } t_in_item;

    typedef struct packed {
        logic [IdxW-1:0] first_index;
        logic [IdxW-1:0] second_index;
        logic            too_many;
    } t_out_item;

endpackage

`default_nettype wire

// ----- src/most_separated_points_3d.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Most separated point pair of a 3D point set, picked from the axis extremes.
//
// Input channel: one point per item (signed x, y, z and a last_point flag).
// Points stream in at one item per clock while o_in_stall is low; a set ends with
// the item that has last_point set, and the next item starts a new set.
// Output channel: one item per set, carrying the index of the chosen axis'
// least point, of its greatest point, and too_many when the set held more
// than MaxPoints points (extra points are neither counted nor compared).
//
// Structure: each taken point is folded into the extremes, and the finished set
// is caught in a capture register; the distance work then runs in a four-stage
// pipe (abs difference, square, sum, compare and select), the last stage
// ending in the output register, so one set may end in every cycle unless
// o_in_stall holds the input.
//
// Reset (i_rst_n low, synchronous) empties the pipe and starts a fresh set.
// When the receiver stalls, the result holds on o_out_item and the pipe keeps
// filling its empty stages; o_in_stall rises only once every stage holds a
// result, and then only until the output item is taken.

module most_separated_points_3d
    import msp3_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire           i_out_stall,
    output t_out_item     o_out_item
);

    // Running set state
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_ovf, n_ovf;
    t_coord          r_ext [NumSlots][NumAxes];
    t_coord          n_ext [NumSlots][NumAxes];
    t_idx            r_idx [NumSlots];
    t_idx            n_idx [NumSlots];

    // Pipe stages
    logic            r_v1, r_v2, r_v3, r_v4, r_out_valid;
    t_coord          r_s1_ext [NumSlots][NumAxes];
    t_idx            r_s1_idx [NumSlots];
    logic            r_s1_ovf;
    logic [DiffW-1:0] r_s2_diff [NumAxes][NumAxes];
    logic [DiffW-1:0] n_s2_diff [NumAxes][NumAxes];
    t_idx            r_s2_idx [NumSlots];
    logic            r_s2_ovf;
    logic [SqW-1:0]  r_s3_sq [NumAxes][NumAxes];
    t_idx            r_s3_idx [NumSlots];
    logic            r_s3_ovf;
    logic [SumW-1:0] r_s4_sum [NumAxes];
    logic [SumW-1:0] n_s4_sum [NumAxes];
    t_idx            r_s4_idx [NumSlots];
    logic            r_s4_ovf;
    t_out_item       r_out, n_out;

    logic            in_acc, last_acc;
    logic            rdy_out, rdy4, rdy3, rdy2, rdy1;
    t_coord          pt [NumAxes];
    t_axis           sel;

    // Stage readiness: a stage takes an item when empty or when it moves on
    assign rdy_out = !r_out_valid || !i_out_stall;
    assign rdy4    = !r_v4 || rdy_out;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;

    assign o_in_stall = !rdy1;
    assign in_acc     = i_in_valid && rdy1;
    assign last_acc   = in_acc && i_in_item.last_point;

    assign pt[0] = i_in_item.coord_x;
    assign pt[1] = i_in_item.coord_y;
    assign pt[2] = i_in_item.coord_z;

    // Fold the incoming point into the extremes
    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        n_ext = r_ext;
        n_idx = r_idx;
        if (in_acc) begin
            if (r_cnt == CntW'(MaxPoints)) begin
                n_ovf = 1'b1;
            end else if (r_cnt == '0) begin
                for (int s = 0; s < NumSlots; s++) begin
                    n_idx[s] = '0;
                    for (int k = 0; k < NumAxes; k++) begin
                        n_ext[s][k] = pt[k];
                    end
                end
                n_cnt = CntW'(1);
            end else begin
                for (int a = 0; a < NumAxes; a++) begin
                    if ($signed(pt[a]) < $signed(r_ext[2*a][a])) begin
                        n_idx[2*a] = r_cnt[IdxW-1:0];
                        for (int k = 0; k < NumAxes; k++) begin
                            n_ext[2*a][k] = pt[k];
                        end
                    end
                    if ($signed(pt[a]) > $signed(r_ext[2*a+1][a])) begin
                        n_idx[2*a+1] = r_cnt[IdxW-1:0];
                        for (int k = 0; k < NumAxes; k++) begin
                            n_ext[2*a+1][k] = pt[k];
                        end
                    end
                end
                n_cnt = r_cnt + CntW'(1);
            end
        end
    end

    // Absolute coordinate differences of each axis pair
    always_comb begin
        logic signed [CoordW:0] d;
        for (int a = 0; a < NumAxes; a++) begin
            for (int k = 0; k < NumAxes; k++) begin
                d = {r_s1_ext[2*a+1][k][CoordW-1], r_s1_ext[2*a+1][k]}
                  - {r_s1_ext[2*a][k][CoordW-1],   r_s1_ext[2*a][k]};
                if (d < 0) begin
                    n_s2_diff[a][k] = DiffW'(-d);
                end else begin
                    n_s2_diff[a][k] = DiffW'(d);
                end
            end
        end
    end

    // Sum the squared differences per axis pair
    always_comb begin
        for (int a = 0; a < NumAxes; a++) begin
            n_s4_sum[a] = SumW'(r_s3_sq[a][0]) + SumW'(r_s3_sq[a][1])
                        + SumW'(r_s3_sq[a][2]);
        end
    end

    // Pick the widest pair, X unless Y or Z wins strictly
    always_comb begin
        if (r_s4_sum[1] > r_s4_sum[0] && r_s4_sum[1] > r_s4_sum[2]) begin
            sel = AXIS_Y;
        end else if (r_s4_sum[2] > r_s4_sum[0] && r_s4_sum[2] > r_s4_sum[1]) begin
            sel = AXIS_Z;
        end else begin
            sel = AXIS_X;
        end
        n_out.too_many = r_s4_ovf;
        case (sel)
            AXIS_Y: begin
                n_out.first_index  = r_s4_idx[2];
                n_out.second_index = r_s4_idx[3];
            end
            AXIS_Z: begin
                n_out.first_index  = r_s4_idx[4];
                n_out.second_index = r_s4_idx[5];
            end
            default: begin
                n_out.first_index  = r_s4_idx[0];
                n_out.second_index = r_s4_idx[1];
            end
        endcase
    end

    // Control registers: set counters and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (last_acc) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end
            if (rdy1) begin
                r_v1 <= last_acc;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy_out) begin
                r_out_valid <= r_v4;
            end
        end
    end

    // Payload registers: advance each stage when it takes an item
    always_ff @(posedge i_clk) begin
        r_ext <= n_ext;
        r_idx <= n_idx;
        if (rdy1 && last_acc) begin
            r_s1_ext <= n_ext;
            r_s1_idx <= n_idx;
            r_s1_ovf <= n_ovf;
        end
        if (rdy2 && r_v1) begin
            r_s2_diff <= n_s2_diff;
            r_s2_idx  <= r_s1_idx;
            r_s2_ovf  <= r_s1_ovf;
        end
        if (rdy3 && r_v2) begin
            for (int a = 0; a < NumAxes; a++) begin
                for (int k = 0; k < NumAxes; k++) begin
                    r_s3_sq[a][k] <= r_s2_diff[a][k] * r_s2_diff[a][k];
                end
            end
            r_s3_idx <= r_s2_idx;
            r_s3_ovf <= r_s2_ovf;
        end
        if (rdy4 && r_v3) begin
            r_s4_sum <= n_s4_sum;
            r_s4_idx <= r_s3_idx;
            r_s4_ovf <= r_s3_ovf;
        end
        if (rdy_out && r_v4) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ----- src/msp3_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module msp3_checker
    import msp3_pkg::*;
(
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_valid,
    input wire            o_in_stall,
    input wire t_in_item  i_in_item,
    input wire            o_out_valid,
    input wire            i_out_stall,
    input wire t_out_item o_out_item
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result changed");

    // Reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Input stalls only when a result is held back by the receiver
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with the output free");

endmodule

bind most_separated_points_3d msp3_checker u_msp3_checker (.*);

`default_nettype wire

// ----- tb/most_separated_points_3d_test.sv -----
`timescale 1ns / 1ps

module most_separated_points_3d_test
    import msp3_pkg::*;
();

    localparam t_coord CoordMin = -32768;
    localparam t_coord CoordMax = 32767;

    // How a set draws its coordinates along one axis
    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EDGE
    } t_spread;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // Shared controls: quiet turns idling off on both sides, hold_len asks for a hold-off
    bit quiet    = 1'b0;
    int hold_len = 0;

    int mismatch_count = 0;

    // Running extremes of the current point set
    int     held    = 0;
    bit     spilled = 1'b0;
    int     ext_idx [NumSlots];
    t_coord ext_pt  [NumSlots][NumAxes];

    t_out_item expected_pairs [$];

    most_separated_points_3d DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task report_mismatch(string field, int got, int want);
        if (mismatch_count < 40) begin
            $display("mismatch at %0t ns: %s got %0d want %0d", $realtime, field, got, want);
        end
        mismatch_count++;
    endtask

    // Fold one accepted point into the extremes; queue the chosen pair on a last point
    function automatic void absorb_point(t_in_item pt);
        t_coord c [NumAxes];
        longint span [NumAxes];
        longint dd;
        t_axis pick;
        t_out_item res;
        int a, k, s, sel;
        c[0] = pt.coord_x;
        c[1] = pt.coord_y;
        c[2] = pt.coord_z;
        if (held >= MaxPoints) begin
            spilled = 1'b1;
        end else if (held == 0) begin
            for (s = 0; s < NumSlots; s++) begin
                ext_idx[s] = 0;
                for (k = 0; k < NumAxes; k++) ext_pt[s][k] = c[k];
            end
            held = 1;
        end else begin
            // strict compares keep the earliest point on ties
            for (a = 0; a < NumAxes; a++) begin
                if (c[a] < ext_pt[2*a][a]) begin
                    ext_idx[2*a] = held;
                    for (k = 0; k < NumAxes; k++) ext_pt[2*a][k] = c[k];
                end
                if (c[a] > ext_pt[2*a+1][a]) begin
                    ext_idx[2*a+1] = held;
                    for (k = 0; k < NumAxes; k++) ext_pt[2*a+1][k] = c[k];
                end
            end
            held++;
        end
        if (pt.last_point) begin
            for (a = 0; a < NumAxes; a++) begin
                span[a] = 0;
                for (k = 0; k < NumAxes; k++) begin
                    dd = longint'(ext_pt[2*a+1][k]) - longint'(ext_pt[2*a][k]);
                    span[a] += dd * dd;
                end
            end
            pick = AXIS_X;
            if (span[AXIS_Y] > span[AXIS_X] && span[AXIS_Y] > span[AXIS_Z]) begin
                pick = AXIS_Y;
            end else if (span[AXIS_Z] > span[AXIS_X] && span[AXIS_Z] > span[AXIS_Y]) begin
                pick = AXIS_Z;
            end
            sel = int'(pick);
            res.first_index  = t_idx'(ext_idx[2*sel]);
            res.second_index = t_idx'(ext_idx[2*sel+1]);
            res.too_many     = spilled;
            expected_pairs.push_back(res);
            // start a fresh set
            held    = 0;
            spilled = 1'b0;
            for (s = 0; s < NumSlots; s++) begin
                ext_idx[s] = 0;
                for (k = 0; k < NumAxes; k++) ext_pt[s][k] = '0;
            end
        end
    endfunction

    // Predict on every accepted point, check every accepted result
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) absorb_point(i_in_item);
            if (o_out_valid && !i_out_stall) begin
                if (expected_pairs.size() == 0) begin
                    report_mismatch("result with no set pending", 1, 0);
                end else begin
                    want = expected_pairs.pop_front();
                    if (o_out_item.first_index !== want.first_index)
                        report_mismatch("first_index", o_out_item.first_index, want.first_index);
                    if (o_out_item.second_index !== want.second_index)
                        report_mismatch("second_index", o_out_item.second_index,
                                        want.second_index);
                    if (o_out_item.too_many !== want.too_many)
                        report_mismatch("too_many", o_out_item.too_many, want.too_many);
                end
            end
        end
    end

    // Hold the output off for a requested stretch, else stall at random unless quiet
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            i_out_stall <= 1'b1;
            hold_len = hold_len - 1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 21);
        end
    end

    function automatic t_coord random_coord(t_spread spread);
        t_coord c;
        case (spread)
            SPREAD_NARROW: c = t_coord'(int'($urandom_range(8)) - 4);
            SPREAD_EDGE: begin
                case ($urandom_range(3))
                    0:       c = CoordMin;
                    1:       c = CoordMax;
                    2:       c = '0;
                    default: c = '1;
                endcase
            end
            default: c = t_coord'($urandom);
        endcase
        return c;
    endfunction

    // Offer one point, maybe after idling first, and hold it until taken
    task send_point(t_in_item pt);
        if (!quiet && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= pt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait for every queued pair to come back
    task end_burst();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pairs.size() != 0) @(posedge i_clk);
    endtask

    task test_single_points();
        send_point(t_in_item'{CoordMin, CoordMin, CoordMin, 1'b1});
        send_point(t_in_item'{CoordMax, CoordMax, CoordMax, 1'b1});
        send_point(t_in_item'{CoordMin, CoordMax, t_coord'(0), 1'b1});
        send_point(t_in_item'{t_coord'(16'h5555), t_coord'(16'haaaa), t_coord'(-1), 1'b1});
        end_burst();
    endtask

    task test_axis_choice();
        // X kept on a tie: every axis picks the same two points
        send_point(t_in_item'{t_coord'(0), t_coord'(0), t_coord'(0), 1'b0});
        send_point(t_in_item'{t_coord'(100), t_coord'(3), t_coord'(-2), 1'b1});
        // Y wins outright
        send_point(t_in_item'{t_coord'(5), t_coord'(0), t_coord'(0), 1'b0});
        send_point(t_in_item'{t_coord'(0), t_coord'(-100), t_coord'(1), 1'b0});
        send_point(t_in_item'{t_coord'(0), t_coord'(100), t_coord'(0), 1'b1});
        // Z wins across the full range
        send_point(t_in_item'{t_coord'(7), t_coord'(7), CoordMin, 1'b0});
        send_point(t_in_item'{t_coord'(7), t_coord'(7), CoordMax, 1'b1});
        // X equals Y above Z: X kept
        send_point(t_in_item'{t_coord'(-10), t_coord'(0), t_coord'(0), 1'b0});
        send_point(t_in_item'{t_coord'(10), t_coord'(0), t_coord'(0), 1'b0});
        send_point(t_in_item'{t_coord'(0), t_coord'(-10), t_coord'(0), 1'b0});
        send_point(t_in_item'{t_coord'(0), t_coord'(10), t_coord'(0), 1'b1});
        // Y equals Z above X: neither strictly wins, so X
        send_point(t_in_item'{t_coord'(0), t_coord'(-10), t_coord'(0), 1'b0});
        send_point(t_in_item'{t_coord'(0), t_coord'(10), t_coord'(0), 1'b0});
        send_point(t_in_item'{t_coord'(0), t_coord'(0), t_coord'(-10), 1'b0});
        send_point(t_in_item'{t_coord'(0), t_coord'(0), t_coord'(10), 1'b1});
        // opposite corners: all three spans equal
        send_point(t_in_item'{CoordMin, CoordMin, CoordMin, 1'b0});
        send_point(t_in_item'{CoordMax, CoordMax, CoordMax, 1'b1});
        end_burst();
    endtask

    task test_ties();
        // repeated points keep the earliest index everywhere
        send_point(t_in_item'{t_coord'(3), t_coord'(3), t_coord'(3), 1'b0});
        send_point(t_in_item'{t_coord'(3), t_coord'(3), t_coord'(3), 1'b0});
        send_point(t_in_item'{t_coord'(3), t_coord'(3), t_coord'(3), 1'b1});
        // a later equal maximum does not move the index
        send_point(t_in_item'{t_coord'(0), t_coord'(0), t_coord'(0), 1'b0});
        send_point(t_in_item'{t_coord'(5), t_coord'(0), t_coord'(0), 1'b0});
        send_point(t_in_item'{t_coord'(5), t_coord'(1), t_coord'(0), 1'b1});
        end_burst();
    endtask

    task test_overflow();
        t_in_item pt;
        int i;
        // extra points at the edges must be ignored; last flag lands on an extra point
        for (i = 0; i < MaxPoints + 3; i++) begin
            if (i < MaxPoints) begin
                pt = t_in_item'{random_coord(SPREAD_NARROW), random_coord(SPREAD_NARROW),
                                random_coord(SPREAD_NARROW), 1'b0};
            end else begin
                pt = t_in_item'{random_coord(SPREAD_EDGE), random_coord(SPREAD_EDGE),
                                random_coord(SPREAD_EDGE), i == MaxPoints + 2};
            end
            send_point(pt);
        end
        end_burst();
    endtask

    task test_backpressure();
        int i;
        @(negedge i_clk);
        hold_len = 300;
        @(posedge i_clk);
        // keep offering one-point sets while the output is held off
        for (i = 0; i < 40; i++) begin
            send_point(t_in_item'{random_coord(SPREAD_FULL), random_coord(SPREAD_FULL),
                                  random_coord(SPREAD_FULL), 1'b1});
        end
        end_burst();
    endtask

    // Stream whole sets of random length, each axis drawn its own way
    task stream_random_sets(int n_items);
        t_in_item pt;
        t_spread sx, sy, sz;
        int sent, len, pick, i;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(19);
            if (pick < 13) len = $urandom_range(1, 6);
            else if (pick < 19) len = $urandom_range(7, 40);
            else len = 1;
            sx = t_spread'($urandom_range(2));
            sy = t_spread'($urandom_range(2));
            sz = t_spread'($urandom_range(2));
            for (i = 0; i < len; i++) begin
                pt = t_in_item'{random_coord(sx), random_coord(sy), random_coord(sz),
                                i == len - 1};
                send_point(pt);
            end
            sent += len;
        end
    endtask

    task test_random();
        stream_random_sets(30);
        end_burst();
        // a stretch with no idling on either side
        @(negedge i_clk);
        quiet = 1'b1;
        @(posedge i_clk);
        stream_random_sets(60);
        end_burst();
        @(negedge i_clk);
        quiet = 1'b0;
        @(posedge i_clk);
        stream_random_sets(30);
        end_burst();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_points();
        test_axis_choice();
        test_ties();
        test_overflow();
        test_backpressure();
        test_random();
        // let any stray result show up
        repeat (12) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
